// ===== rtl/linear_diophantine_solver_defines.svh =====
// ----------------------------------------------------------------------------
// linear_diophantine_solver_defines
// Assertion macros shared by the solver RTL.
// ----------------------------------------------------------------------------
`ifndef LINEAR_DIOPHANTINE_SOLVER_DEFINES_SVH
`define LINEAR_DIOPHANTINE_SOLVER_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define LDS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define LDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lds_pkg.sv =====
// ----------------------------------------------------------------------------
// lds_pkg
// Types and constants for the linear Diophantine solver.
// ----------------------------------------------------------------------------
package lds_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int CNT_W      = $clog2(WORD_WIDTH + 1);

    localparam logic [1:0] ST_SOLVED  = 2'd0;
    localparam logic [1:0] ST_NO_SOLN = 2'd1;
    localparam logic [1:0] ST_GCD_ZERO = 2'd2;

    typedef struct packed {
        logic signed [WORD_WIDTH-1:0] a_value;
        logic signed [WORD_WIDTH-1:0] b_value;
        logic signed [WORD_WIDTH-1:0] c_value;
    } req_t;

    typedef struct packed {
        logic [1:0]                   status;
        logic signed [WORD_WIDTH-1:0] x_coeff;
        logic signed [WORD_WIDTH-1:0] y_coeff;
        logic signed [WORD_WIDTH-1:0] gcd_value;
    } rsp_t;

endpackage

// ===== rtl/linear_diophantine_solver.sv =====
// ----------------------------------------------------------------------------
// linear_diophantine_solver
// Extended Euclid on a and b, then scaling of the Bezout pair by c/g.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries a request {a, b, c}; output
//   channel out_valid/out_stall carries {status, x, y, gcd}.
//   One request is worked on at a time; in_stall is high while busy or
//   while the result register is still full. The next request is taken the
//   cycle after the result is accepted.
//   Each Euclid step passes through the zero check, a bit-serial restoring
//   divider and two shift-and-add multiplies of q by s and t. The check c/g
//   and the scaling reuse the same divider and multiplier. A 32-bit input
//   needs up to about 46 steps. Both coefficients zero end at the zero
//   check with status ST_GCD_ZERO.
//   Reset empties the block and clears out_valid. While out_stall is high
//   a shown result holds and no new request is taken.
// ----------------------------------------------------------------------------
module linear_diophantine_solver
    import lds_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  req_t in_data,
    output logic out_valid,
    input  logic out_stall,
    output rsp_t out_data
);
`include "linear_diophantine_solver_defines.svh"

    localparam int W = WORD_WIDTH;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_FDIV  = 3'd4;
    localparam logic [2:0] S_FMUL  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [W-1:0] pr_reg, r_reg, ps_reg, s_reg, pt_reg, t_reg, c_reg;
    logic [W-1:0] pr_next, r_next, ps_next, s_next, pt_next, t_next, c_next;
    // divider
    logic [W-1:0] dq_reg, dq_next, drem_reg, drem_next, dd_reg, dd_next;
    logic         qneg_reg, qneg_next, rneg_reg, rneg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    // multiplier: q held in mq, shifted right; accumulators for two products
    logic [W-1:0] mq_reg, mq_next, ma_reg, ma_next, mb_reg, mb_next;
    logic [W-1:0] acca_reg, acca_next, accb_reg, accb_next;
    logic         out_valid_reg, out_valid_next;
    rsp_t         out_reg, out_next;

    logic [W:0]   trial;
    logic [W-1:0] qv, rv;

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        mag = v[W-1] ? (~v + 1'b1) : v;
    endfunction

    assign trial    = {drem_reg, dq_reg[W-1]} - {1'b0, dd_reg};
    assign qv       = qneg_reg ? (~dq_reg + 1'b1) : dq_reg;
    assign rv       = rneg_reg ? (~drem_reg + 1'b1) : drem_reg;
    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next = state_reg;
        pr_next = pr_reg; r_next = r_reg; ps_next = ps_reg; s_next = s_reg;
        pt_next = pt_reg; t_next = t_reg; c_next = c_reg;
        dq_next = dq_reg; drem_next = drem_reg; dd_next = dd_reg;
        qneg_next = qneg_reg; rneg_next = rneg_reg; cnt_next = cnt_reg;
        mq_next = mq_reg; ma_next = ma_reg; mb_next = mb_reg;
        acca_next = acca_reg; accb_next = accb_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next = out_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    pr_next = in_data.a_value; r_next = in_data.b_value;
                    c_next = in_data.c_value;
                    ps_next = W'(1); s_next = '0; pt_next = '0; t_next = W'(1);
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cnt_next = '0;
                drem_next = '0;
                if (r_reg != '0)
                begin
                    dq_next = mag(pr_reg); dd_next = mag(r_reg);
                    qneg_next = pr_reg[W-1] ^ r_reg[W-1]; rneg_next = pr_reg[W-1];
                    state_next = S_DIV;
                end
                else if (pr_reg == '0)
                begin
                    out_next = '{ST_GCD_ZERO, ps_reg, pt_reg, pr_reg};
                    state_next = S_DONE;
                end
                else
                begin
                    dq_next = mag(c_reg); dd_next = mag(pr_reg);
                    qneg_next = c_reg[W-1] ^ pr_reg[W-1]; rneg_next = c_reg[W-1];
                    state_next = S_FDIV;
                end
            end
            S_DIV, S_FDIV:
            begin
                if (cnt_reg == CNT_W'(W))
                begin
                    cnt_next = '0;
                    mq_next = qv; acca_next = '0; accb_next = '0;
                    if (state_reg == S_DIV)
                    begin
                        ma_next = s_reg; mb_next = t_reg;
                        state_next = S_MUL;
                    end
                    else if (rv != '0)
                    begin
                        out_next = '{ST_NO_SOLN, ps_reg, pt_reg, pr_reg};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ma_next = ps_reg; mb_next = pt_reg;
                        state_next = S_FMUL;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (!trial[W])
                        drem_next = trial[W-1:0];
                    else
                        drem_next = {drem_reg[W-2:0], dq_reg[W-1]};
                    dq_next = {dq_reg[W-2:0], !trial[W]};
                end
            end
            S_MUL, S_FMUL:
            begin
                if (cnt_reg == CNT_W'(W))
                begin
                    if (state_reg == S_MUL)
                    begin
                        pr_next = r_reg; r_next = rv;
                        ps_next = s_reg; s_next = ps_reg - acca_reg;
                        pt_next = t_reg; t_next = pt_reg - accb_reg;
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        out_next = '{ST_SOLVED, acca_reg, accb_reg, pr_reg};
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (mq_reg[0])
                    begin
                        acca_next = acca_reg + ma_reg;
                        accb_next = accb_reg + mb_reg;
                    end
                    mq_next = mq_reg >> 1;
                    ma_next = ma_reg << 1;
                    mb_next = mb_reg << 1;
                end
            end
            S_DONE:
            begin
                out_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pr_reg <= pr_next; r_reg <= r_next; ps_reg <= ps_next; s_reg <= s_next;
        pt_reg <= pt_next; t_reg <= t_next; c_reg <= c_next;
        dq_reg <= dq_next; drem_reg <= drem_next; dd_reg <= dd_next;
        qneg_reg <= qneg_next; rneg_reg <= rneg_next;
        mq_reg <= mq_next; ma_reg <= ma_next; mb_reg <= mb_next;
        acca_reg <= acca_next; accb_reg <= accb_next;
        out_reg <= out_next;
    end

    `LDS_ASSERT_NEXT(a_hold_out, out_valid && out_stall, out_valid && $stable(out_data),
        "result changed while stalled")
    `LDS_ASSERT_IMP(a_busy_no_out, state_reg != S_IDLE && state_reg != S_DONE, !out_valid,
        "result shown while working")
    `LDS_ASSERT_IMP(a_cnt_range, 1'b1, cnt_reg <= CNT_W'(W), "step counter overran")
    `LDS_ASSERT_IMP(a_status_code, out_valid, out_data.status != 2'd3, "bad status code")

endmodule
